// ----- rtl/core/sfk_pkg.sv -----
// ----------------------------------------------------------------------------
// sfk_pkg: shared types and constants of the spring force kernel
// Field widths, status codes, register indexes, sideband structs and the
// small arithmetic helpers used by the pipeline.
// ----------------------------------------------------------------------------
package sfk_pkg;

  localparam int COORD_W     = 24;
  localparam int FORCE_W     = 32;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 128;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int LEN_W       = 32;
  localparam int STRAIN_W    = 31;
  localparam int LIMIT_W     = 16;
  localparam int GAIN_W      = 32;
  localparam int SCALED_W    = 52;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_CUR  = 2'd1;
  localparam logic [1:0] ST_ZERO_REST = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRUCT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd6554;

  // per-spring data carried alongside the arithmetic
  typedef struct packed {
    logic                         bend;
    logic [2:0]                   csgn;
    logic [2:0][COORD_W-1:0]      cmag;
    logic                         sneg;
    logic                         zc;
    logic                         zr;
    logic [LEN_W-1:0]             lc;
  } sfk_meta_t;

  typedef struct packed {
    logic                         bend;
    logic [2:0][COORD_W-1:0]      cur;
  } sfk_sqrt_side_t;

  typedef struct packed {
    sfk_meta_t                    meta;
    logic                         sat;
  } sfk_strain_side_t;

  typedef struct packed {
    sfk_meta_t                    meta;
    logic [STRAIN_W-1:0]          m;
    logic                         over;
    logic                         sat;
  } sfk_limit_side_t;

  typedef struct packed {
    sfk_meta_t                    meta;
    logic [FORCE_W-1:0]           fmag;
  } sfk_vec_side_t;

  // square of a signed coordinate, always non-negative
  function automatic logic [2*COORD_W-2:0] square24(input logic [COORD_W-1:0] x);
    logic signed [2*COORD_W-1:0] p;
    p = $signed(x) * $signed(x);
    return p[2*COORD_W-2:0];
  endfunction

  // sign and magnitude to a saturated two's complement word
  function automatic logic [FORCE_W-1:0] pack32(input logic neg,
                                                input logic [FORCE_W-1:0] mag);
    logic [FORCE_W-1:0] m;
    if (neg) begin
      m = (mag > 32'h8000_0000) ? 32'h8000_0000 : mag;
      return -m;
    end
    return (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
  endfunction

endpackage

// ----- rtl/core/spring_force_kernel.sv -----
// ----------------------------------------------------------------------------
// spring_force_kernel: Hooke spring force with quadratic strain limit
// Streaming kernel, one spring in and one force result out per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one spring per transfer: current and rest difference vectors
//   (signed Q12.12) in s_tdata and the bending kind bit in s_tuser.
//   m_* returns the force vector on the first endpoint and the scalar force
//   (signed Q20.12, saturated) in m_tdata and the status code in m_tuser.
//   cfg_we/cfg_index/cfg_data write the stiffness and strain limit registers;
//   write them only while no spring is in flight.
// The pipeline depth is set by the two square roots (32 stages), the strain
// divide (31), the limit divide (52) and the vector divide (32), each one bit
// per stage. Throughput is one spring per cycle while the receiver is not
// stalling. Reset clears all valid bits and loads the register reset values.
// When the receiver stalls with a result held, the whole pipeline freezes
// and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module spring_force_kernel (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cur_dx, cur_dy, cur_dz, rest_dx, rest_dy, rest_dz
  input  logic [sfk_pkg::IN_TDATA_W-1:0]   s_tdata,
  // is_bend
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // force_x, force_y, force_z, force_scalar
  output logic [sfk_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // status
  output logic [1:0]                       m_tuser,
  input  logic                             cfg_we,
  input  logic [sfk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfk_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import sfk_pkg::*;

  logic en;

  logic [GAIN_W-1:0]  struct_k;
  logic [GAIN_W-1:0]  bend_k;
  logic [LIMIT_W-1:0] strain_limit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      struct_k     <= '0;
      bend_k       <= '0;
      strain_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRUCT: struct_k     <= cfg_data;
        REG_BEND:   bend_k       <= cfg_data;
        REG_LIMIT:  strain_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a held result is stalled
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage a: squares of all coordinates
  logic                          va;
  logic [2:0][2*COORD_W-2:0]     sqc_a, sqr_a;
  logic [2:0][COORD_W-1:0]       c_a;
  logic                          bend_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqc_a[i] <= square24(s_tdata[COORD_W*i +: COORD_W]);
        sqr_a[i] <= square24(s_tdata[COORD_W*(i+3) +: COORD_W]);
      end
      c_a    <= s_tdata[3*COORD_W-1:0];
      bend_a <= s_tuser;
    end
  end

  // stage b: sums of squares, scaled for eight extra length bits
  logic                          vb;
  logic [1:0][63:0]              rad_b;
  sfk_sqrt_side_t                side_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_b[0]    <= {48'(sqc_a[0]) + 48'(sqc_a[1]) + 48'(sqc_a[2]), 16'h0};
      rad_b[1]    <= {48'(sqr_a[0]) + 48'(sqr_a[1]) + 48'(sqr_a[2]), 16'h0};
      side_b.bend <= bend_a;
      side_b.cur  <= c_a;
    end
  end

  // both lengths
  logic                                vs;
  logic [1:0][LEN_W-1:0]               root_s;
  logic [$bits(sfk_sqrt_side_t)-1:0]   side_s_raw;
  sfk_sqrt_side_t                      side_s;

  sfk_sqrt #(
    .LANES (2),
    .SW    ($bits(sfk_sqrt_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb),
    .in_rad    (rad_b),
    .in_side   (side_b),
    .out_valid (vs),
    .out_root  (root_s),
    .out_side  (side_s_raw)
  );

  assign side_s = side_s_raw;

  // stage c: length difference, zero checks, coordinate magnitudes
  logic                 sneg_n;
  logic [LEN_W-1:0]     diff_n;
  logic                 vc;
  logic [LEN_W-1:0]     diff_c, lr_c;
  logic                 sat_c;
  sfk_meta_t            meta_c;

  always_comb begin
    sneg_n = root_s[0] > root_s[1];
    diff_n = sneg_n ? root_s[0] - root_s[1] : root_s[1] - root_s[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_c      <= diff_n;
      lr_c        <= root_s[1];
      sat_c       <= {15'h0, diff_n} >= {root_s[1], 15'h0};
      meta_c.bend <= side_s.bend;
      meta_c.sneg <= sneg_n;
      meta_c.zc   <= root_s[0] == '0;
      meta_c.zr   <= root_s[1] == '0;
      meta_c.lc   <= root_s[0];
      for (int i = 0; i < 3; i++) begin
        meta_c.csgn[i] <= side_s.cur[i][COORD_W-1];
        meta_c.cmag[i] <= side_s.cur[i][COORD_W-1] ? -side_s.cur[i] : side_s.cur[i];
      end
    end
  end

  // strain: diff * 2^16 / rest length
  sfk_strain_side_t                      side_c;
  logic                                  vd;
  logic [0:0][STRAIN_W-1:0]              quo_d;
  logic [$bits(sfk_strain_side_t)-1:0]   side_d_raw;
  sfk_strain_side_t                      side_d;

  assign side_c.meta = meta_c;
  assign side_c.sat  = sat_c;

  sfk_div #(
    .LANES (1),
    .DW    (LEN_W),
    .QW    (STRAIN_W),
    .SW    ($bits(sfk_strain_side_t))
  ) u_div_strain (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vc),
    .in_rem    ({15'h0, diff_c[LEN_W-1:15]}),
    .in_low    ({diff_c[14:0], 16'h0}),
    .in_div    (lr_c),
    .in_side   (side_c),
    .out_valid (vd),
    .out_quo   (quo_d),
    .out_side  (side_d_raw)
  );

  assign side_d = side_d_raw;

  // stage e: saturated strain magnitude and effective limit
  logic                  ve;
  logic [STRAIN_W-1:0]   m_e;
  logic [LIMIT_W-1:0]    lim_e;
  sfk_meta_t             meta_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_e    <= side_d.sat ? '1 : quo_d[0];
      lim_e  <= (strain_limit == '0) ? LIMIT_W'(1) : strain_limit;
      meta_e <= side_d.meta;
    end
  end

  // stage f: strain squared and over-limit test
  logic                    vf;
  logic [2*STRAIN_W-1:0]   p_f;
  logic [STRAIN_W-1:0]     m_f;
  logic                    over_f;
  logic [LIMIT_W-1:0]      lim_f;
  sfk_meta_t               meta_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_f    <= (2*STRAIN_W)'(m_e) * (2*STRAIN_W)'(m_e);
      m_f    <= m_e;
      over_f <= m_e > STRAIN_W'(lim_e);
      lim_f  <= lim_e;
      meta_f <= meta_e;
    end
  end

  // limit scaling: strain^2 / limit, clipped at 52 bits
  sfk_limit_side_t                       side_f;
  logic                                  vg0;
  logic [0:0][SCALED_W-1:0]              quo_g;
  logic [$bits(sfk_limit_side_t)-1:0]    side_g_raw;
  sfk_limit_side_t                       side_g;

  assign side_f.meta = meta_f;
  assign side_f.m    = m_f;
  assign side_f.over = over_f;
  assign side_f.sat  = {6'h0, p_f[2*STRAIN_W-1:SCALED_W]} >= lim_f;

  sfk_div #(
    .LANES (1),
    .DW    (LIMIT_W),
    .QW    (SCALED_W),
    .SW    ($bits(sfk_limit_side_t))
  ) u_div_limit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vf),
    .in_rem    ({6'h0, p_f[2*STRAIN_W-1:SCALED_W]}),
    .in_low    (p_f[SCALED_W-1:0]),
    .in_div    (lim_f),
    .in_side   (side_f),
    .out_valid (vg0),
    .out_quo   (quo_g),
    .out_side  (side_g_raw)
  );

  assign side_g = side_g_raw;

  // stage g: pick scaled strain and stiffness
  logic                  vg;
  logic [SCALED_W-1:0]   q_g;
  logic [GAIN_W-1:0]     k_g;
  sfk_meta_t             meta_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= vg0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (!side_g.over) begin
        q_g <= SCALED_W'(side_g.m);
      end else if (side_g.sat) begin
        q_g <= '1;
      end else begin
        q_g <= quo_g[0];
      end
      k_g    <= side_g.meta.bend ? bend_k : struct_k;
      meta_g <= side_g.meta;
    end
  end

  // stage h: two partial products of strain times stiffness
  logic                  vh;
  logic [57:0]           ph_h, pl_h;
  sfk_meta_t             meta_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
    end else if (en) begin
      vh <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_h   <= 58'(q_g[SCALED_W-1:26]) * 58'(k_g);
      pl_h   <= 58'(q_g[25:0]) * 58'(k_g);
      meta_h <= meta_g;
    end
  end

  // stage i: combine, drop 20 fraction bits, saturate the magnitude
  logic [83:0]           full_n;
  logic [63:0]           cap_n;
  logic                  vi;
  logic [FORCE_W-1:0]    fmag_i;
  sfk_meta_t             meta_i;

  always_comb begin
    full_n = {ph_h, 26'h0} + 84'(pl_h);
    cap_n  = meta_h.sneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vi <= 1'b0;
    end else if (en) begin
      vi <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fmag_i <= (full_n[83:20] > cap_n) ? cap_n[FORCE_W-1:0] : full_n[51:20];
      meta_i <= meta_h;
    end
  end

  // stage j: force magnitude times each coordinate magnitude
  logic                  vj;
  logic [2:0][62:0]      prod_j;
  logic [FORCE_W-1:0]    fmag_j;
  sfk_meta_t             meta_j;

  always_ff @(posedge clk) begin
    if (rst) begin
      vj <= 1'b0;
    end else if (en) begin
      vj <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_j[i] <= 63'(fmag_i) * 63'({meta_i.cmag[i], 8'h0});
      end
      fmag_j <= fmag_i;
      meta_j <= meta_i;
    end
  end

  // vector components: product / current length
  sfk_vec_side_t                       side_j;
  logic [2:0][LEN_W-1:0]               rem_j;
  logic [2:0][LEN_W-1:0]               low_j;
  logic                                vk;
  logic [2:0][LEN_W-1:0]               quo_k;
  logic [$bits(sfk_vec_side_t)-1:0]    side_k_raw;
  sfk_vec_side_t                       side_k;

  assign side_j.meta = meta_j;
  assign side_j.fmag = fmag_j;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_j[i] = {1'b0, prod_j[i][62:32]};
      low_j[i] = prod_j[i][31:0];
    end
  end

  sfk_div #(
    .LANES (3),
    .DW    (LEN_W),
    .QW    (LEN_W),
    .SW    ($bits(sfk_vec_side_t))
  ) u_div_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vj),
    .in_rem    (rem_j),
    .in_low    (low_j),
    .in_div    (meta_j.lc),
    .in_side   (side_j),
    .out_valid (vk),
    .out_quo   (quo_k),
    .out_side  (side_k_raw)
  );

  assign side_k = side_k_raw;

  // output stage: signs, saturation and special cases
  logic [OUT_TDATA_W-1:0] tdata_n;
  logic [1:0]             status_n;

  always_comb begin
    tdata_n = '0;
    for (int i = 0; i < 3; i++) begin
      tdata_n[FORCE_W*i +: FORCE_W] =
        pack32((side_k.meta.sneg != side_k.meta.csgn[i]) && (quo_k[i] != '0), quo_k[i]);
    end
    tdata_n[FORCE_W*3 +: FORCE_W] = pack32(side_k.meta.sneg, side_k.fmag);
    priority if (side_k.meta.zr) begin
      status_n = ST_ZERO_REST;
      tdata_n  = '0;
    end else if (side_k.meta.zc) begin
      status_n = ST_ZERO_CUR;
      tdata_n  = '0;
    end else begin
      status_n = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vk;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= tdata_n;
      m_tuser <= status_n;
    end
  end

  // a flagged spring carries no force
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("flagged result with nonzero force");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_ZERO_CUR || m_tuser == ST_ZERO_REST))
    else $error("undefined status code");

  // zero scalar force gives a zero force vector
  a_zero_scalar: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[127:96] == '0 |-> m_tdata[95:0] == '0)
    else $error("force vector without scalar force");

endmodule

// ----- rtl/core/sfk_sqrt.sv -----
// ----------------------------------------------------------------------------
// sfk_sqrt: pipelined integer square root
// One result bit per stage over a 64-bit radicand, several lanes side by
// side, a sideband word travels with the valid bit.
// ----------------------------------------------------------------------------
module sfk_sqrt #(
  parameter int LANES = 2,
  parameter int SW    = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [LANES-1:0][63:0] in_rad,
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  output logic [LANES-1:0][31:0] out_root,
  output logic [SW-1:0]          out_side
);

  localparam int STAGES = 32;

  logic                   vld  [STAGES+1];
  logic [LANES-1:0][63:0] rv   [STAGES+1];
  logic [LANES-1:0][63:0] rr   [STAGES+1];
  logic [SW-1:0]          side [STAGES+1];

  assign vld[0]  = in_valid;
  assign rv[0]   = in_rad;
  assign rr[0]   = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
    logic [LANES-1:0][63:0] trial;
    logic [LANES-1:0][63:0] v_next;
    logic [LANES-1:0][63:0] r_next;

    // one restoring step per lane
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = rr[s][l] + BIT;
        if (rv[s][l] >= trial[l]) begin
          v_next[l] = rv[s][l] - trial[l];
          r_next[l] = (rr[s][l] >> 1) + BIT;
        end else begin
          v_next[l] = rv[s][l];
          r_next[l] = rr[s][l] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rv[s+1]   <= v_next;
        rr[s+1]   <= r_next;
        side[s+1] <= side[s];
      end
    end
  end

  // root fits the low half
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_root[l] = rr[STAGES][l][31:0];
    end
  end

  assign out_valid = vld[STAGES];
  assign out_side  = side[STAGES];

endmodule

// ----- rtl/core/sfk_div.sv -----
// ----------------------------------------------------------------------------
// sfk_div: pipelined restoring divider
// One quotient bit per stage, shared divisor over several lanes. The caller
// supplies the high part of the dividend (below the divisor) as the starting
// remainder and the low QW bits to be shifted in.
// ----------------------------------------------------------------------------
module sfk_div #(
  parameter int LANES = 1,
  parameter int DW    = 32,
  parameter int QW    = 32,
  parameter int SW    = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [LANES-1:0][DW-1:0] in_rem,
  input  logic [LANES-1:0][QW-1:0] in_low,
  input  logic [DW-1:0]          in_div,
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  output logic [LANES-1:0][QW-1:0] out_quo,
  output logic [SW-1:0]          out_side
);

  logic                     vld  [QW+1];
  logic [LANES-1:0][DW-1:0] rem  [QW+1];
  logic [LANES-1:0][QW-1:0] low  [QW+1];
  logic [LANES-1:0][QW-1:0] quo  [QW+1];
  logic [DW-1:0]            dvs  [QW+1];
  logic [SW-1:0]            side [QW+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_rem;
  assign low[0]  = in_low;
  assign quo[0]  = '0;
  assign dvs[0]  = in_div;
  assign side[0] = in_side;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [LANES-1:0][DW:0]   trial;
    logic [LANES-1:0]         qbit;
    logic [LANES-1:0][DW-1:0] rem_next;

    // shift in the next dividend bit and try a subtract
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l]    = {rem[s][l], low[s][l][QW-1]};
        qbit[l]     = trial[l] >= {1'b0, dvs[s]};
        rem_next[l] = qbit[l] ? DW'(trial[l] - {1'b0, dvs[s]}) : trial[l][DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= rem_next;
        for (int l = 0; l < LANES; l++) begin
          low[s+1][l] <= low[s][l] << 1;
          quo[s+1][l] <= {quo[s][l][QW-2:0], qbit[l]};
        end
        dvs[s+1]  <= dvs[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_side  = side[QW];

endmodule
